// ===== design/lpm_pkg.sv =====
`default_nettype none

package lpm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;

    typedef logic [1:0] req_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [1:0] status_t;
    typedef logic signed [6:0] match_t;

    localparam req_t REQ_ADD = 2'd0;
    localparam req_t REQ_DEL = 2'd1;
    localparam req_t REQ_LOOKUP = 2'd2;
    localparam req_t REQ_RSVD = 2'd3;

    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_BAD = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam len_t LEN_MAX = 6'd32;
    localparam match_t MATCH_NONE = 7'sh7f;
    localparam match_t MATCH_ZERO = 7'sh00;

    typedef struct packed {
        logic  valid;
        len_t  len;
        addr_t prefix;
    } entry_t;

    // network mask for a length of 0 to 32
    function automatic addr_t net_mask(input len_t len);
        addr_t m;
        if (len >= LEN_MAX)
        begin
            m = '1;
        end
        else
        begin
            m = ~(addr_t'('1) >> len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/longest_prefix_match_table.sv =====
// IPv4 longest-prefix-match table. Holds up to TABLE_ENTRIES prefixes in one
// simple dual-port memory (one read, one write per cycle, registered read data).
// Each request beat (add, delete or lookup) is answered by exactly one result
// beat. A well-formed request scans every entry once through the memory read
// port; a malformed add or delete, or the reserved request kind, skips the
// scan. A request's result is written only when the output register can take
// it, so a stalled earlier result delays it. The result sits in an output
// register, so the next request is taken and scanned while an earlier result
// still waits. After reset the block clears every entry, one per cycle, and
// takes no request until that pass is over.

`default_nettype none

module longest_prefix_match_table #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lpm_pkg::req_t    req_type,
    input  wire lpm_pkg::addr_t   address,
    input  wire lpm_pkg::len_t    prefix_len,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lpm_pkg::status_t      status,
    output lpm_pkg::match_t       match_len
);
    import lpm_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN = 2'd3;

    entry_t mem [TABLE_ENTRIES];
    entry_t mem_q_reg;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    req_t kind_reg, kind_next;
    addr_t addr_reg, addr_next;
    len_t len_reg, len_next;
    logic bad_reg, bad_next;

    logic hit_reg, hit_next;
    logic free_found_reg, free_found_next;
    logic [IW-1:0] free_slot_reg, free_slot_next;
    logic found_reg, found_next;
    len_t best_reg, best_next;

    logic out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    match_t match_reg, match_next;

    logic rd_en;
    logic [IW-1:0] rd_addr;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    entry_t wr_data;

    logic out_free;
    logic in_beat;
    logic req_bad;
    logic same_entry;
    logic covers;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign match_len = match_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign req_bad = (req_type == REQ_RSVD) ||
                     ((req_type != REQ_LOOKUP) &&
                      ((prefix_len > LEN_MAX) || ((address & ~net_mask(prefix_len)) != '0)));

    assign same_entry = (mem_q_reg.prefix == addr_reg) && (mem_q_reg.len == len_reg);
    assign covers = ((addr_reg ^ mem_q_reg.prefix) & net_mask(mem_q_reg.len)) == '0;

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        iss_cnt_next = iss_cnt_reg;
        rd_pend_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        kind_next = kind_reg;
        addr_next = addr_reg;
        len_next = len_reg;
        bad_next = bad_reg;
        hit_next = hit_reg;
        free_found_next = free_found_reg;
        free_slot_next = free_slot_reg;
        found_next = found_reg;
        best_next = best_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        match_next = match_reg;
        rd_en = 1'b0;
        rd_addr = iss_cnt_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    kind_next = req_type;
                    addr_next = address;
                    len_next = prefix_len;
                    bad_next = req_bad;
                    hit_next = 1'b0;
                    free_found_next = 1'b0;
                    free_slot_next = '0;
                    found_next = 1'b0;
                    best_next = '0;
                    iss_cnt_next = '0;
                    state_next = req_bad ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_cnt_reg != CNT_END)
                begin
                    rd_en = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next = iss_cnt_reg[IW-1:0];
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_FIN;
                end
                if (rd_pend_reg)
                begin
                    if (mem_q_reg.valid)
                    begin
                        if (kind_reg == REQ_LOOKUP)
                        begin
                            if (covers && (!found_reg || (mem_q_reg.len > best_reg)))
                            begin
                                found_next = 1'b1;
                                best_next = mem_q_reg.len;
                            end
                        end
                        else if (same_entry)
                        begin
                            hit_next = 1'b1;
                            if (kind_reg == REQ_DEL)
                            begin
                                wr_en = 1'b1;
                                wr_addr = rd_idx_reg;
                                wr_data = '0;
                            end
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next = rd_idx_reg;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                    match_next = MATCH_ZERO;
                    if (bad_reg)
                    begin
                        status_next = ST_BAD;
                    end
                    else if (kind_reg == REQ_LOOKUP)
                    begin
                        status_next = ST_OK;
                        match_next = found_reg ? match_t'({1'b0, best_reg}) : MATCH_NONE;
                    end
                    else if ((kind_reg == REQ_ADD) && !hit_reg && !free_found_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                    if (!bad_reg && (kind_reg == REQ_ADD) && !hit_reg && free_found_reg)
                    begin
                        wr_en = 1'b1;
                        wr_addr = free_slot_reg;
                        wr_data.valid = 1'b1;
                        wr_data.len = len_reg;
                        wr_data.prefix = addr_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
            iss_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            iss_cnt_reg <= iss_cnt_next;
            rd_pend_reg <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and scan payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        len_reg <= len_next;
        bad_reg <= bad_next;
        hit_reg <= hit_next;
        free_found_reg <= free_found_next;
        free_slot_reg <= free_slot_next;
        found_reg <= found_next;
        best_reg <= best_next;
        status_reg <= status_next;
        match_reg <= match_next;
    end

endmodule

`default_nettype wire
